@@ rtl/core/natural_order_string_compare_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Natural order string compare unit assertion macros
// Shared property forms for the assertion checkers of the compare unit.
// ----------------------------------------------------------------------------
`ifndef NATURAL_ORDER_STRING_COMPARE_UNIT_DEFINES_SVH
`define NATURAL_ORDER_STRING_COMPARE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define NOSCU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define NOSCU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/noscu_pkg.sv @@
// ----------------------------------------------------------------------------
// Natural order string compare package
// Shared constants, sequencer states and character helpers.
// ----------------------------------------------------------------------------
package noscu_pkg;

  localparam int MAX_LEN_DEFAULT = 256;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam int NUM_W = 64;
  localparam int ORDER_W = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EVAL,
    ST_LACC,
    ST_LWAIT,
    ST_RACC,
    ST_RWAIT,
    ST_NCMP,
    ST_OUT
  } state_e;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    v = c - CHAR_ZERO;
    return v[3:0];
  endfunction

endpackage

@@ rtl/core/natural_order_string_compare_unit.sv @@
// ----------------------------------------------------------------------------
// Natural order string compare unit
// Load: one byte or terminator transfer per cycle while idle, stalled in compare.
// Compare: each byte pair takes a fetch and an evaluate state, each digit an
// accumulate and a wait state, each pair of numbers a compare state; the pace is
// set by the shared 64-bit adder and the registered read of the two string RAMs.
// Reset clears lengths, flags, sequencer and output valid; RAM contents are kept.
// ----------------------------------------------------------------------------
module natural_order_string_compare_unit #(
  parameter int MAX_LEN = noscu_pkg::MAX_LEN_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               side_i,
  input  logic [7:0]                         char_code_i,
  input  logic                               is_terminator_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [noscu_pkg::ORDER_W-1:0] order_o,
  output logic                               too_long_o
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int NW = noscu_pkg::NUM_W;
  localparam int OW = noscu_pkg::ORDER_W;

  noscu_pkg::state_e state_q, state_d;

  logic [LW-1:0] llen_q, llen_d, rlen_q, rlen_d;
  logic [LW-1:0] idx_l_q, idx_l_d, idx_r_q, idx_r_d;
  logic          lcomp_q, lcomp_d, rcomp_q, rcomp_d;
  logic          ovf_q, ovf_d;
  logic [NW-1:0] lnum_q, lnum_d, rnum_q, rnum_d;
  logic [OW-1:0] res_q, res_d;
  logic          out_valid_q, out_valid_d;
  logic [OW-1:0] order_q, order_d;
  logic          too_long_q, too_long_d;

  logic          we_l, we_r;
  logic [7:0]    byte_l, byte_r;
  logic          end_l, end_r, dig_l, dig_r;
  logic signed [8:0] byte_diff;
  logic [NW-1:0] add_a, add_b, add_sum;
  logic [3:0]    add_c;
  logic          in_xfer;

  noscu_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (we_l),
    .waddr_i (llen_q[AW-1:0]),
    .wdata_i (char_code_i),
    .raddr_i (idx_l_q[AW-1:0]),
    .rdata_o (byte_l)
  );

  noscu_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (we_r),
    .waddr_i (rlen_q[AW-1:0]),
    .wdata_i (char_code_i),
    .raddr_i (idx_r_q[AW-1:0]),
    .rdata_o (byte_r)
  );

  assign in_stall_o = (state_q != noscu_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign end_l = (idx_l_q >= llen_q) || (byte_l == 8'h00);
  assign end_r = (idx_r_q >= rlen_q) || (byte_r == 8'h00);
  assign dig_l = noscu_pkg::is_digit(byte_l);
  assign dig_r = noscu_pkg::is_digit(byte_r);
  assign byte_diff = $signed({byte_l[7], byte_l}) - $signed({byte_r[7], byte_r});

  assign add_sum = add_a + add_b + {{(NW-4){1'b0}}, add_c};

  always_comb begin
    state_d     = state_q;
    llen_d      = llen_q;
    rlen_d      = rlen_q;
    idx_l_d     = idx_l_q;
    idx_r_d     = idx_r_q;
    lcomp_d     = lcomp_q;
    rcomp_d     = rcomp_q;
    ovf_d       = ovf_q;
    lnum_d      = lnum_q;
    rnum_d      = rnum_q;
    res_d       = res_q;
    order_d     = order_q;
    too_long_d  = too_long_q;
    out_valid_d = out_valid_q && out_stall_i;
    we_l        = 1'b0;
    we_r        = 1'b0;
    add_a       = '0;
    add_b       = '0;
    add_c       = '0;

    case (state_q)
      noscu_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (!side_i && !lcomp_q) begin
            if (is_terminator_i) begin
              lcomp_d = 1'b1;
            end else if (llen_q < LW'(MAX_LEN)) begin
              we_l   = 1'b1;
              llen_d = llen_q + LW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end else if (side_i && !rcomp_q) begin
            if (is_terminator_i) begin
              rcomp_d = 1'b1;
            end else if (rlen_q < LW'(MAX_LEN)) begin
              we_r   = 1'b1;
              rlen_d = rlen_q + LW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (lcomp_d && rcomp_d) begin
            idx_l_d = '0;
            idx_r_d = '0;
            state_d = noscu_pkg::ST_FETCH;
          end
        end
      end
      noscu_pkg::ST_FETCH: begin
        state_d = noscu_pkg::ST_EVAL;
      end
      noscu_pkg::ST_EVAL: begin
        if (end_l || end_r) begin
          if (!end_r) begin
            res_d = '1;
          end else if (!end_l) begin
            res_d = OW'(1);
          end else begin
            res_d = '0;
          end
          state_d = noscu_pkg::ST_OUT;
        end else if (dig_l && dig_r) begin
          lnum_d  = '0;
          rnum_d  = '0;
          state_d = noscu_pkg::ST_LACC;
        end else if (dig_l) begin
          res_d   = '1;
          state_d = noscu_pkg::ST_OUT;
        end else if (dig_r) begin
          res_d   = OW'(1);
          state_d = noscu_pkg::ST_OUT;
        end else if (byte_diff != 9'sd0) begin
          res_d   = {{(OW-9){byte_diff[8]}}, byte_diff};
          state_d = noscu_pkg::ST_OUT;
        end else begin
          idx_l_d = idx_l_q + LW'(1);
          idx_r_d = idx_r_q + LW'(1);
          state_d = noscu_pkg::ST_FETCH;
        end
      end
      noscu_pkg::ST_LACC: begin
        if (!end_l && dig_l) begin
          add_a   = {lnum_q[NW-4:0], 3'b000};
          add_b   = {lnum_q[NW-2:0], 1'b0};
          add_c   = noscu_pkg::digit_value(byte_l);
          lnum_d  = add_sum;
          idx_l_d = idx_l_q + LW'(1);
          state_d = noscu_pkg::ST_LWAIT;
        end else begin
          state_d = noscu_pkg::ST_RACC;
        end
      end
      noscu_pkg::ST_LWAIT: begin
        state_d = noscu_pkg::ST_LACC;
      end
      noscu_pkg::ST_RACC: begin
        if (!end_r && dig_r) begin
          add_a   = {rnum_q[NW-4:0], 3'b000};
          add_b   = {rnum_q[NW-2:0], 1'b0};
          add_c   = noscu_pkg::digit_value(byte_r);
          rnum_d  = add_sum;
          idx_r_d = idx_r_q + LW'(1);
          state_d = noscu_pkg::ST_RWAIT;
        end else begin
          state_d = noscu_pkg::ST_NCMP;
        end
      end
      noscu_pkg::ST_RWAIT: begin
        state_d = noscu_pkg::ST_RACC;
      end
      noscu_pkg::ST_NCMP: begin
        add_a = lnum_q;
        add_b = ~rnum_q;
        add_c = 4'd1;
        if (add_sum != '0) begin
          res_d   = add_sum[OW-1:0];
          state_d = noscu_pkg::ST_OUT;
        end else begin
          state_d = noscu_pkg::ST_EVAL;
        end
      end
      noscu_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          order_d     = res_q;
          too_long_d  = ovf_q;
          llen_d      = '0;
          rlen_d      = '0;
          lcomp_d     = 1'b0;
          rcomp_d     = 1'b0;
          ovf_d       = 1'b0;
          state_d     = noscu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = noscu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= noscu_pkg::ST_IDLE;
      llen_q      <= '0;
      rlen_q      <= '0;
      lcomp_q     <= 1'b0;
      rcomp_q     <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      llen_q      <= llen_d;
      rlen_q      <= rlen_d;
      lcomp_q     <= lcomp_d;
      rcomp_q     <= rcomp_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_l_q    <= idx_l_d;
    idx_r_q    <= idx_r_d;
    lnum_q     <= lnum_d;
    rnum_q     <= rnum_d;
    res_q      <= res_d;
    order_q    <= order_d;
    too_long_q <= too_long_d;
  end

  assign out_valid_o = out_valid_q;
  assign order_o     = $signed(order_q);
  assign too_long_o  = too_long_q;

endmodule

@@ rtl/core/noscu_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module noscu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = noscu_pkg::MAX_LEN_DEFAULT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/noscu_checker.sv @@
// ----------------------------------------------------------------------------
// Natural order string compare checker
// Port-level assertions on handshake and sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`include "natural_order_string_compare_unit_defines.svh"

module noscu_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                side_i,
  input logic [7:0]                          char_code_i,
  input logic                                is_terminator_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [noscu_pkg::ORDER_W-1:0] order_o,
  input logic                                too_long_o
);

  `NOSCU_ASSERT_NEXT(a_out_valid_hold, out_valid_o && out_stall_i, out_valid_o, "result valid dropped while stalled")
  `NOSCU_ASSERT_NEXT(a_out_data_hold, out_valid_o && out_stall_i, $stable(order_o) && $stable(too_long_o), "result payload changed while stalled")
  `NOSCU_ASSERT_SAME(a_result_after_busy, $rose(out_valid_o), $past(in_stall_o), "result appeared without a compare phase")
  `NOSCU_ASSERT_SAME(a_release_with_result, $fell(in_stall_o), out_valid_o, "input released without a pending result")

endmodule

bind natural_order_string_compare_unit noscu_checker u_noscu_checker (.*);

@@ tb/natural_order_check_pkg.sv @@
// ----------------------------------------------------------------------------
// Natural order compare checker
// Tracks the two strings from the accepted input transfers, predicts the
// natural-order verdict of each completed pair and checks the unit's results
// against the oldest pending prediction.
// ----------------------------------------------------------------------------
package natural_order_check_pkg;

  localparam int STR_CAP = noscu_pkg::MAX_LEN_DEFAULT;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [31:0] order;
    logic        too_long;
  } verdict_t;

  class collation_tracker;
    logic [7:0]  lhs_text [STR_CAP];
    logic [7:0]  rhs_text [STR_CAP];
    int unsigned lhs_len;
    int unsigned rhs_len;
    bit          lhs_closed;
    bit          rhs_closed;
    bit          truncated;
    verdict_t    pending_verdicts[$];
    int          errors;

    function new();
      lhs_len = 0;
      rhs_len = 0;
      lhs_closed = 0;
      rhs_closed = 0;
      truncated = 0;
      errors = 0;
    endfunction

    function bit numeral(logic [7:0] c);
      return (c >= ASCII_ZERO) && (c <= ASCII_NINE);
    endfunction

    function int as_int8(logic [7:0] c);
      return (c >= 8'd128) ? int'(c) - 256 : int'(c);
    endfunction

    function logic [31:0] collate();
      int unsigned ll;
      int unsigned rl;
      int unsigned i;
      int unsigned j;
      logic [63:0] lnum;
      logic [63:0] rnum;
      int          sa;
      int          sb;
      ll = 0;
      while (ll < lhs_len && lhs_text[ll] != 8'h00) ll++;
      rl = 0;
      while (rl < rhs_len && rhs_text[rl] != 8'h00) rl++;
      i = 0;
      j = 0;
      while (i < ll && j < rl) begin
        if (numeral(lhs_text[i]) && numeral(rhs_text[j])) begin
          lnum = 64'd0;
          rnum = 64'd0;
          while (i < ll && numeral(lhs_text[i])) begin
            lnum = lnum * 64'd10 + ({56'd0, lhs_text[i]} - 64'd48);
            i++;
          end
          while (j < rl && numeral(rhs_text[j])) begin
            rnum = rnum * 64'd10 + ({56'd0, rhs_text[j]} - 64'd48);
            j++;
          end
          if (lnum != rnum) return 32'(lnum - rnum);
        end else if (numeral(lhs_text[i])) begin
          return 32'hFFFF_FFFF;
        end else if (numeral(rhs_text[j])) begin
          return 32'd1;
        end else begin
          sa = as_int8(lhs_text[i]);
          sb = as_int8(rhs_text[j]);
          if (sa != sb) return 32'(sa - sb);
          i++;
          j++;
        end
      end
      if (j < rl) return 32'hFFFF_FFFF;
      if (i < ll) return 32'd1;
      return 32'd0;
    endfunction

    // Returns 1 when the transfer changes the pair, 0 when it is dropped.
    function bit note_transfer(bit side, logic [7:0] code, bit term);
      verdict_t v;
      bit       taken;
      taken = 1;
      if (!side) begin
        if (lhs_closed) taken = 0;
        else if (term) lhs_closed = 1;
        else if (lhs_len < STR_CAP) begin
          lhs_text[lhs_len] = code;
          lhs_len++;
        end else truncated = 1;
      end else begin
        if (rhs_closed) taken = 0;
        else if (term) rhs_closed = 1;
        else if (rhs_len < STR_CAP) begin
          rhs_text[rhs_len] = code;
          rhs_len++;
        end else truncated = 1;
      end
      if (lhs_closed && rhs_closed) begin
        v.order = collate();
        v.too_long = truncated;
        pending_verdicts.push_back(v);
        lhs_len = 0;
        rhs_len = 0;
        lhs_closed = 0;
        rhs_closed = 0;
        truncated = 0;
      end
      return taken;
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction

    task report(string msg);
      $display("natural_order_check: mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [31:0] order, logic too_long);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        report($sformatf("result with none pending, order=%0d", $signed(order)));
        return;
      end
      want = pending_verdicts.pop_front();
      if (order !== want.order)
        report($sformatf("order %0d, predicted %0d", $signed(order), $signed(want.order)));
      if (too_long !== want.too_long)
        report($sformatf("too_long %0b, predicted %0b", too_long, want.too_long));
    endtask
  endclass

endpackage

@@ tb/natural_order_string_compare_unit_test.sv @@
// ----------------------------------------------------------------------------
// Natural order string compare unit test
// Sends string pairs one byte per transfer, directed corner pairs first and
// then random pairs, most built around shared stems, with bursty input and a
// patterned output stall; every result is checked against the prediction.
// ----------------------------------------------------------------------------
module natural_order_string_compare_unit_test;
  import natural_order_check_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_GOAL = 600;
  localparam int PAIR_GOAL = 26;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        side_i;
  logic [7:0]  char_code_i;
  logic        is_terminator_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic signed [noscu_pkg::ORDER_W-1:0] order_o;
  logic        too_long_o;

  collation_tracker collator = new();
  int burst_left;
  int items_taken;
  int pairs_done;
  int rx_cycles;

  natural_order_string_compare_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .side_i          (side_i),
    .char_code_i     (char_code_i),
    .is_terminator_i (is_terminator_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .order_o         (order_o),
    .too_long_o      (too_long_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("natural_order_string_compare_unit_test: done, errors");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) collator.check_result(order_o, too_long_o);
    rx_cycles <= rx_cycles + 1;
    case ((rx_cycles / 160) % 4)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 1) == 0);
      2: out_stall_i <= ($urandom_range(0, 4) != 0);
      default: out_stall_i <= ((rx_cycles % 5) < 2);
    endcase
  end

  function automatic byte_q_t q_of(string s);
    byte_q_t q;
    for (int k = 0; k < s.len(); k++) q.push_back(s[k]);
    return q;
  endfunction

  function automatic byte_q_t joined(byte_q_t a, byte_q_t b);
    byte_q_t q;
    q = a;
    foreach (b[k]) q.push_back(b[k]);
    return q;
  endfunction

  function automatic byte_q_t rand_digits(int n);
    byte_q_t q;
    repeat (n) q.push_back(8'(48 + $urandom_range(0, 9)));
    return q;
  endfunction

  function automatic byte_q_t rand_alnum(int n);
    byte_q_t q;
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) q.push_back(8'(48 + $urandom_range(0, 9)));
      else q.push_back(8'(97 + $urandom_range(0, 25)));
    end
    return q;
  endfunction

  function automatic byte_q_t rand_segment();
    byte_q_t q;
    int      kind;
    int      n;
    logic [7:0] punct [6];
    punct = '{8'h2F, 8'h3A, 8'h20, 8'h2D, 8'h2E, 8'h5F};
    kind = $urandom_range(0, 19);
    if (kind < 8) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 22) : $urandom_range(1, 4);
      if (kind == 0) q.push_back(8'h30);
      q = joined(q, rand_digits(n));
    end else if (kind < 14) begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 1) == 0) q.push_back(8'(97 + $urandom_range(0, 25)));
        else q.push_back(8'(65 + $urandom_range(0, 25)));
      end
    end else if (kind < 17) begin
      q.push_back(punct[$urandom_range(0, 5)]);
    end else if (kind < 19) begin
      q.push_back(8'($urandom_range(1, 255)));
    end else begin
      q.push_back(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(128, 255)));
    end
    return q;
  endfunction

  function automatic byte_q_t rand_text(int segs);
    byte_q_t q;
    repeat (segs) q = joined(q, rand_segment());
    return q;
  endfunction

  task automatic send_item(input bit side, input logic [7:0] code, input bit term);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) gap = 0;
      else if ($urandom_range(0, 7) == 0) gap = $urandom_range(10, 30);
      else gap = $urandom_range(1, 4);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    side_i <= side;
    char_code_i <= code;
    is_terminator_i <= term;
    do @(posedge clk_i); while (in_stall_o);
    items_taken += int'(collator.note_transfer(side, code, term));
    burst_left--;
  endtask

  // Interleave both strings, or send lhs first; noise hits a side already
  // terminated while the other one is still open.
  task automatic send_pair(input byte_q_t lhs, input byte_q_t rhs, input bit noisy);
    int li;
    int ri;
    bit pick_rhs;
    bit lhs_first;
    li = 0;
    ri = 0;
    lhs_first = ($urandom_range(0, 3) == 0);
    while (li <= lhs.size() || ri <= rhs.size()) begin
      if (li > lhs.size()) pick_rhs = 1;
      else if (ri > rhs.size()) pick_rhs = 0;
      else if (lhs_first) pick_rhs = 0;
      else pick_rhs = $urandom_range(0, 1);
      if (!pick_rhs) begin
        if (li == lhs.size()) send_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
        else send_item(1'b0, lhs[li], 1'b0);
        li++;
      end else begin
        if (ri == rhs.size()) send_item(1'b1, 8'($urandom_range(0, 255)), 1'b1);
        else send_item(1'b1, rhs[ri], 1'b0);
        ri++;
      end
      if (noisy && $urandom_range(0, 2) == 0) begin
        if (li > lhs.size() && ri <= rhs.size())
          send_item(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        else if (ri > rhs.size() && li <= lhs.size())
          send_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
    pairs_done++;
  endtask

  task automatic await_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (collator.pending() != 0);
  endtask

  initial begin
    byte_q_t lhs;
    byte_q_t rhs;
    byte_q_t stem;
    byte_q_t tail;
    int      shape;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    side_i = 1'b0;
    char_code_i = 8'h00;
    is_terminator_i = 1'b0;
    burst_left = 0;
    items_taken = 0;
    pairs_done = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pair(q_of(""), q_of(""), 0);
    send_pair(q_of("abc"), q_of("abc"), 0);
    send_pair(q_of("ab"), q_of("abc"), 0);
    send_pair(q_of("abc"), q_of("ab"), 0);
    send_pair(q_of("a"), q_of("1"), 0);
    send_pair(q_of("1"), q_of("a"), 0);
    send_pair(q_of("a10"), q_of("a9"), 0);
    send_pair(q_of("x2y"), q_of("x10y"), 0);
    send_pair(q_of("a09b"), q_of("a9c"), 0);
    send_pair(q_of("4294967296"), q_of("0"), 0);
    send_pair(q_of("18446744073709551616"), q_of("0x"), 0);
    send_pair(q_of("99999999999999999999"), q_of("1"), 0);
    send_pair('{8'h80}, '{8'h7F}, 0);
    send_pair('{8'hFF}, '{8'h01}, 0);
    lhs = q_of("ab");
    lhs.push_back(8'h00);
    send_pair(joined(lhs, q_of("zz")), q_of("ab"), 0);
    send_pair('{8'h00}, q_of("a"), 0);
    send_pair(q_of("q"), q_of("r"), 1);
    send_pair(rand_alnum(257), q_of("x"), 0);
    await_results();

    while (items_taken < ITEM_GOAL || pairs_done < PAIR_GOAL) begin
      shape = $urandom_range(0, 29);
      stem = rand_text($urandom_range(0, 3));
      tail = rand_text($urandom_range(0, 2));
      lhs = stem;
      rhs = stem;
      if (shape == 0) begin
        lhs = rand_alnum($urandom_range(240, 270));
        rhs = ($urandom_range(0, 1) == 0) ? lhs : rand_text(2);
      end else if (shape < 4) begin
        lhs = rand_text($urandom_range(0, 4));
        rhs = rand_text($urandom_range(0, 4));
      end else if (shape < 8) begin
        lhs = joined(lhs, tail);
        rhs = joined(rhs, tail);
      end else if (shape < 12) begin
        if ($urandom_range(0, 1) == 0) lhs = joined(lhs, tail);
        else rhs = joined(rhs, tail);
      end else if (shape < 22) begin
        lhs = joined(lhs, rand_digits($urandom_range(1, 5)));
        rhs = joined(rhs, rand_digits($urandom_range(1, 5)));
        lhs = joined(lhs, tail);
        rhs = joined(rhs, tail);
      end else begin
        lhs = joined(joined(lhs, rand_segment()), tail);
        rhs = joined(joined(rhs, rand_segment()), tail);
      end
      send_pair(lhs, rhs, ($urandom_range(0, 5) == 0));
      if ($urandom_range(0, 11) == 0) await_results();
    end

    await_results();
    repeat (50) @(posedge clk_i);
    if (collator.errors == 0) begin
      $display("natural_order_string_compare_unit_test: done, clean");
    end else begin
      $display("natural_order_string_compare_unit_test: done, errors");
    end
    $finish;
  end

endmodule
